// ----- sv/cheirality_pose_vote_unit_defines.svh -----
`ifndef CHEIRALITY_POSE_VOTE_UNIT_DEFINES_SVH
`define CHEIRALITY_POSE_VOTE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CPV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CPV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cpv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cpv_pkg;

    localparam int POSE_W  = 2;
    localparam int COORD_W = 32;
    localparam int ROT_W   = 18;
    localparam int COUNT_W = 17;

    // p - t is exact in one extra bit
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + ROT_W;
    localparam int SUM2_W = PROD_W + 1;
    localparam int SUM3_W = PROD_W + 2;

    localparam int QDEPTH = 8;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCNT_W = QAW + 1;

    typedef struct packed {
        logic [POSE_W-1:0] pose;
        logic              vote;
        logic              last;
    } t_vote;

    typedef struct packed {
        logic  valid;
        t_vote data;
    } t_push;

    typedef struct packed {
        logic [QCNT_W-1:0] level;
        logic              empty;
        t_vote             head;
    } t_q_stat;

endpackage

`default_nettype wire

// ----- sv/cpv_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cpv_in_if;
    import cpv_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [POSE_W-1:0]          pose_index;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic signed [COORD_W-1:0]  point_z;
    logic signed [ROT_W-1:0]    rot_row_x;
    logic signed [ROT_W-1:0]    rot_row_y;
    logic signed [ROT_W-1:0]    rot_row_z;
    logic signed [COORD_W-1:0]  trans_x;
    logic signed [COORD_W-1:0]  trans_y;
    logic signed [COORD_W-1:0]  trans_z;
    logic                       last_point;

    modport source (
        output valid, pose_index, point_x, point_y, point_z,
               rot_row_x, rot_row_y, rot_row_z, trans_x, trans_y, trans_z, last_point,
        input  ready
    );

    modport sink (
        input  valid, pose_index, point_x, point_y, point_z,
               rot_row_x, rot_row_y, rot_row_z, trans_x, trans_y, trans_z, last_point,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/cpv_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cpv_out_if;
    import cpv_pkg::*;

    logic               valid;
    logic               ready;
    logic [POSE_W-1:0]  best_pose;
    logic [COUNT_W-1:0] best_count;

    modport source (
        output valid, best_pose, best_count,
        input  ready
    );

    modport sink (
        input  valid, best_pose, best_count,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/cpv_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cpv_front #(
    parameter int NUM_POSES = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    cpv_in_if.sink                 i_pt,
    input  wire cpv_pkg::t_q_stat  i_q_stat,
    output cpv_pkg::t_push         o_push
);
    import cpv_pkg::*;

    // stage 1: differences
    logic                      r_v1;
    logic [POSE_W-1:0]         r_pose1;
    logic                      r_last1;
    logic                      r_ok1;
    logic signed [DIFF_W-1:0]  r_dx, r_dy, r_dz;
    logic signed [ROT_W-1:0]   r_rx, r_ry, r_rz;

    // stage 2: products
    logic                      r_v2;
    logic [POSE_W-1:0]         r_pose2;
    logic                      r_last2;
    logic                      r_ok2;
    logic signed [PROD_W-1:0]  r_p0, r_p1, r_p2;

    // stage 3: partial sum
    logic                      r_v3;
    logic [POSE_W-1:0]         r_pose3;
    logic                      r_last3;
    logic                      r_ok3;
    logic signed [SUM2_W-1:0]  r_s01;
    logic signed [PROD_W-1:0]  r_p2b;

    logic                      accept;
    logic [QCNT_W-1:0]         committed;
    logic signed [SUM3_W-1:0]  sum;

    // queue slots already taken plus words still in the pipe
    assign committed = i_q_stat.level + QCNT_W'(r_v1) + QCNT_W'(r_v2) + QCNT_W'(r_v3);
    assign i_pt.ready = (committed < QCNT_W'(QDEPTH));
    assign accept = i_pt.valid && i_pt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pose1 <= i_pt.pose_index;
        r_last1 <= i_pt.last_point;
        r_ok1   <= (32'(i_pt.pose_index) < NUM_POSES) && !i_pt.point_z[COORD_W-1]
                   && (i_pt.point_z != '0);
        r_dx    <= DIFF_W'(i_pt.point_x) - DIFF_W'(i_pt.trans_x);
        r_dy    <= DIFF_W'(i_pt.point_y) - DIFF_W'(i_pt.trans_y);
        r_dz    <= DIFF_W'(i_pt.point_z) - DIFF_W'(i_pt.trans_z);
        r_rx    <= i_pt.rot_row_x;
        r_ry    <= i_pt.rot_row_y;
        r_rz    <= i_pt.rot_row_z;

        r_pose2 <= r_pose1;
        r_last2 <= r_last1;
        r_ok2   <= r_ok1;
        r_p0    <= PROD_W'(r_dx) * PROD_W'(r_rx);
        r_p1    <= PROD_W'(r_dy) * PROD_W'(r_ry);
        r_p2    <= PROD_W'(r_dz) * PROD_W'(r_rz);

        r_pose3 <= r_pose2;
        r_last3 <= r_last2;
        r_ok3   <= r_ok2;
        r_s01   <= SUM2_W'(r_p0) + SUM2_W'(r_p1);
        r_p2b   <= r_p2;
    end

    assign sum = SUM3_W'(r_s01) + SUM3_W'(r_p2b);

    always_comb begin
        o_push.valid     = r_v3;
        o_push.data.pose = r_pose3;
        o_push.data.last = r_last3;
        o_push.data.vote = r_ok3 && !sum[SUM3_W-1] && (sum != '0);
    end

endmodule

`default_nettype wire

// ----- sv/cpv_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cpv_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cpv_pkg::t_push    i_push,
    input  wire logic              i_pop,
    output cpv_pkg::t_q_stat       o_stat
);
    import cpv_pkg::*;

    t_vote              r_mem [QDEPTH];
    logic [QAW-1:0]     r_wp;
    logic [QAW-1:0]     r_rp;
    logic [QCNT_W-1:0]  r_level;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (i_push.valid) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            r_level <= r_level + QCNT_W'(i_push.valid) - QCNT_W'(i_pop);
        end
    end

    always_comb begin
        o_stat.level = r_level;
        o_stat.empty = (r_level == '0);
        o_stat.head  = r_mem[r_rp];
    end

endmodule

`default_nettype wire

// ----- sv/cpv_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cpv_back #(
    parameter int MAX_POINTS = 65536,
    parameter int NUM_POSES  = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cpv_pkg::t_q_stat  i_q_stat,
    output logic                   o_pop,
    cpv_out_if.source              o_res
);
    import cpv_pkg::*;

    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int IW  = $clog2(NUM_POSES);
    localparam int NP2 = 1 << IW;
    localparam int LV  = IW;

    logic [CW-1:0]  r_cnt [NUM_POSES];
    logic [CW-1:0]  n_cnt [NUM_POSES];

    // registered max tree, level 0 is the snapshot
    logic [CW-1:0]  r_tc [LV+1][NP2];
    logic [IW-1:0]  r_ti [LV+1][NP2];
    logic [LV:0]    r_tv;

    logic           r_ov;
    logic [IW-1:0]  r_op;
    logic [CW-1:0]  r_oc;

    logic           b_adv;
    logic           close;

    assign b_adv = !r_ov || o_res.ready;
    assign o_pop = b_adv && !i_q_stat.empty;
    assign close = o_pop && i_q_stat.head.last;

    always_comb begin
        for (int i = 0; i < NUM_POSES; i++) begin
            logic bump;
            bump = o_pop && i_q_stat.head.vote && (32'(i_q_stat.head.pose) == i)
                   && (r_cnt[i] < CW'(MAX_POINTS));
            n_cnt[i] = r_cnt[i] + CW'(bump);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || close) begin
            for (int i = 0; i < NUM_POSES; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= '0;
            r_ov <= 1'b0;
        end else if (b_adv) begin
            r_tv <= {r_tv[LV-1:0], close};
            r_ov <= r_tv[LV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            for (int i = 0; i < NUM_POSES; i++) begin
                r_tc[0][i] <= n_cnt[i];
                r_ti[0][i] <= IW'(i);
            end
            // padding leaves never win: a tie keeps the left side
            for (int i = NUM_POSES; i < NP2; i++) begin
                r_tc[0][i] <= '0;
                r_ti[0][i] <= IW'(i);
            end
            for (int l = 0; l < LV; l++) begin
                for (int j = 0; j < NP2 / 2; j++) begin
                    if (j < (NP2 >> (l + 1))) begin
                        if (r_tc[l][2*j+1] > r_tc[l][2*j]) begin
                            r_tc[l+1][j] <= r_tc[l][2*j+1];
                            r_ti[l+1][j] <= r_ti[l][2*j+1];
                        end else begin
                            r_tc[l+1][j] <= r_tc[l][2*j];
                            r_ti[l+1][j] <= r_ti[l][2*j];
                        end
                    end
                end
            end
            r_op <= r_ti[LV][0];
            r_oc <= r_tc[LV][0];
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.best_pose  = POSE_W'(r_op);
    assign o_res.best_count = COUNT_W'(r_oc);

endmodule

`default_nettype wire

// ----- sv/cheirality_pose_vote_unit.sv -----
// cheirality pose vote
// i_pt carries one triangulated point per word: pose tag, point, the pose's
// rotation third row and translation, and a last-point mark. o_res carries
// one word per set: best_pose and best_count. Both channels move a word on a
// clock edge where valid and ready are both high.
// A point passes three front stages (difference, multiply, partial sum), then
// the final sign and vote go into an 8-word queue. The back pops one word a
// cycle while o_res is not stalled, updates the saturating counters, and on a
// last point snapshots them into a registered max tree of clog2(NUM_POSES)
// levels before the output register.
// Throughput is one point per cycle; i_pt.ready drops only when the queue
// plus the three front stages hold eight words.
// When o_res stalls, the result holds and the back stops popping; the queue
// fills and then i_pt.ready goes low.
// Synchronous reset clears the counters, queue and all valid flags; i_pt is
// ready on the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module cheirality_pose_vote_unit #(
    parameter int MAX_POINTS = 65536,
    parameter int NUM_POSES  = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cpv_in_if.sink     i_pt,
    cpv_out_if.source  o_res
);
    import cpv_pkg::*;

    t_push    push;
    t_q_stat  q_stat;
    logic     pop;

    cpv_front #(
        .NUM_POSES (NUM_POSES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pt     (i_pt),
        .i_q_stat (q_stat),
        .o_push   (push)
    );

    cpv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_stat  (q_stat)
    );

    cpv_back #(
        .MAX_POINTS (MAX_POINTS),
        .NUM_POSES  (NUM_POSES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_res    (o_res)
    );

endmodule

`default_nettype wire

// ----- sv/cpv_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "cheirality_pose_vote_unit_defines.svh"

module cpv_checker #(
    parameter int MAX_POINTS = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_ready,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [1:0]  i_best_pose,
    input  wire logic [16:0] i_best_count
);

    // result words hold while the sink stalls
    `CPV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_best_pose) && $stable(i_best_count), "result dropped or changed under stall")

    // nothing pending right after reset
    `CPV_ASSERT_NOW(a_reset_clean, i_clk, i_rst_n, $past(!i_rst_n), !i_out_valid && i_in_ready, "state not clean after reset")

    // counts saturate at the point bound
    `CPV_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, i_out_valid && (MAX_POINTS < 131072), 32'(i_best_count) <= MAX_POINTS, "count above point bound")

endmodule

bind cheirality_pose_vote_unit cpv_checker #(
    .MAX_POINTS (MAX_POINTS)
) u_cpv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_pt.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_best_pose  (o_res.best_pose),
    .i_best_count (o_res.best_count)
);

`default_nettype wire

// ----- dv/cheirality_pose_vote_unit_tb.sv -----
`timescale 1ns / 1ps

module cheirality_pose_vote_unit_tb;
    import cpv_pkg::*;

    localparam int NUM_POSES  = 4;
    localparam int MAX_POINTS = 65536;

    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;
    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [ROT_W-1:0]   R_MAX = 18'sh1_ffff;
    localparam logic signed [ROT_W-1:0]   R_MIN = 18'sh2_0000;

    typedef struct {
        logic [POSE_W-1:0]         pose;
        logic signed [COORD_W-1:0] px, py, pz;
        logic signed [ROT_W-1:0]   rx, ry, rz;
        logic signed [COORD_W-1:0] tx, ty, tz;
        logic                      last;
    } point_word;

    typedef struct {
        logic [POSE_W-1:0]  pose;
        logic [COUNT_W-1:0] count;
    } vote_result;

    class pose_vote_board;
        logic [COUNT_W-1:0] tally [NUM_POSES];
        vote_result         winners_q[$];
        int unsigned        fails;

        function new();
            foreach (tally[i]) tally[i] = '0;
            fails = 0;
        endfunction

        function void note_point(point_word w);
            longint signed dot;
            vote_result    r;
            if (w.pose < NUM_POSES && w.pz > 0) begin
                // exact depth sign of r . (p - t)
                dot = longint'(w.rx) * (longint'(w.px) - longint'(w.tx))
                    + longint'(w.ry) * (longint'(w.py) - longint'(w.ty))
                    + longint'(w.rz) * (longint'(w.pz) - longint'(w.tz));
                if (dot > 0 && tally[w.pose] < MAX_POINTS) tally[w.pose]++;
            end
            if (w.last) begin
                r.pose  = '0;
                r.count = tally[0];
                for (int i = 1; i < NUM_POSES; i++) begin
                    if (tally[i] > r.count) begin
                        r.count = tally[i];
                        r.pose  = POSE_W'(i);
                    end
                end
                winners_q = {winners_q, r};
                foreach (tally[i]) tally[i] = '0;
            end
        endfunction

        function void check_result(logic [POSE_W-1:0] pose, logic [COUNT_W-1:0] count);
            vote_result e;
            if (winners_q.size() == 0) begin
                $error("unexpected result word: best_pose %0d, best_count %0d", pose, count);
                fails++;
                return;
            end
            e = winners_q.pop_front();
            if (pose !== e.pose) begin
                $error("best_pose mismatch: expected %0d, actual %0d", e.pose, pose);
                fails++;
            end
            if (count !== e.count) begin
                $error("best_count mismatch: expected %0d, actual %0d", e.count, count);
                fails++;
            end
        endfunction

        function int unsigned pending();
            return winners_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   steady;

    pose_vote_board board = new();

    cpv_in_if  pt_if();
    cpv_out_if res_if();

    cheirality_pose_vote_unit #(
        .MAX_POINTS(MAX_POINTS),
        .NUM_POSES (NUM_POSES)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pt   (pt_if),
        .o_res  (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("cheirality_pose_vote_unit test failed");
        $finish;
    end

    // result side backpressure
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= steady || ($urandom_range(99) >= 12);
        end
    end

    always @(posedge i_clk) begin : point_monitor
        point_word w;
        if (i_rst_n && pt_if.valid && pt_if.ready) begin
            w.pose = pt_if.pose_index;
            w.px   = pt_if.point_x;
            w.py   = pt_if.point_y;
            w.pz   = pt_if.point_z;
            w.rx   = pt_if.rot_row_x;
            w.ry   = pt_if.rot_row_y;
            w.rz   = pt_if.rot_row_z;
            w.tx   = pt_if.trans_x;
            w.ty   = pt_if.trans_y;
            w.tz   = pt_if.trans_z;
            w.last = pt_if.last_point;
            board.note_point(w);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            board.check_result(res_if.best_pose, res_if.best_count);
    end

    function automatic point_word make_point(
        logic [POSE_W-1:0] pose,
        logic signed [COORD_W-1:0] px, py, pz,
        logic signed [ROT_W-1:0] rx, ry, rz,
        logic signed [COORD_W-1:0] tx, ty, tz,
        logic last
    );
        point_word w;
        w.pose = pose;
        w.px = px; w.py = py; w.pz = pz;
        w.rx = rx; w.ry = ry; w.rz = rz;
        w.tx = tx; w.ty = ty; w.tz = tz;
        w.last = last;
        return w;
    endfunction

    // a point guaranteed to vote: z > 0 and rz * (pz - tz) > 0
    function automatic point_word front_point(logic [POSE_W-1:0] pose, logic last);
        point_word   w;
        int unsigned k;
        k = $urandom_range(1, 4096);
        w = make_point(pose, $urandom, $urandom, $urandom_range(1, 32'h7fff_ffff),
                       '0, '0, ROT_W'($urandom_range(1, 131071)),
                       $urandom, $urandom, '0, last);
        w.tz = w.pz - k;
        return w;
    endfunction

    function automatic logic signed [ROT_W-1:0] pick_rot();
        case ($urandom_range(3))
            0:       return R_MAX;
            1:       return R_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord(bit wide);
        if (wide) return $urandom;
        return int'($urandom_range(0, 2**21)) - 2**20;
    endfunction

    function automatic point_word rand_point(logic [POSE_W-1:0] pose, logic last);
        point_word   w;
        int unsigned mode;
        bit          wide;
        mode = $urandom_range(9);
        if (mode == 7) return front_point(pose, last);
        wide = (mode >= 4);
        w = make_point(pose, rand_coord(wide), rand_coord(wide), rand_coord(wide),
                       ROT_W'($urandom), ROT_W'($urandom), ROT_W'($urandom),
                       rand_coord(wide), rand_coord(wide), rand_coord(wide), last);
        if (!wide && $urandom_range(9) < 7) w.pz = $urandom_range(1, 2**20);
        if (mode == 8) begin
            // point on the plane through t: zero dot product
            w.pz = $urandom_range(1, 2**30);
            w.tx = w.px;
            w.ty = w.py;
            w.tz = w.pz;
        end
        if (mode == 9) begin
            w.rx = pick_rot();
            w.ry = pick_rot();
            w.rz = pick_rot();
        end
        return w;
    endfunction

    task automatic send_point(point_word w);
        while (!steady && $urandom_range(99) < 12) begin
            pt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_if.valid      <= 1'b1;
        pt_if.pose_index <= w.pose;
        pt_if.point_x    <= w.px;
        pt_if.point_y    <= w.py;
        pt_if.point_z    <= w.pz;
        pt_if.rot_row_x  <= w.rx;
        pt_if.rot_row_y  <= w.ry;
        pt_if.rot_row_z  <= w.rz;
        pt_if.trans_x    <= w.tx;
        pt_if.trans_y    <= w.ty;
        pt_if.trans_z    <= w.tz;
        pt_if.last_point <= w.last;
        @(posedge i_clk);
        while (pt_if.ready !== 1'b1) @(posedge i_clk);
    endtask

    // hold the point stream until every pending result is out
    task automatic drain();
        pt_if.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    initial begin
        int unsigned       len;
        int unsigned       rand_points;
        logic [POSE_W-1:0] fav;
        logic [POSE_W-1:0] pose;

        rand_points = 0;
        steady      = 1'b0;
        i_rst_n     = 1'b0;
        pt_if.valid      = 1'b0;
        pt_if.pose_index = '0;
        pt_if.point_x    = '0;
        pt_if.point_y    = '0;
        pt_if.point_z    = '0;
        pt_if.rot_row_x  = '0;
        pt_if.rot_row_y  = '0;
        pt_if.rot_row_z  = '0;
        pt_if.trans_x    = '0;
        pt_if.trans_y    = '0;
        pt_if.trans_z    = '0;
        pt_if.last_point = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // nothing in front: zero depth, zero dot, all-zero row, negative z
        send_point(make_point(1, 100, 200, 0, '0, '0, R_MAX, '0, '0, -5, 1'b0));
        send_point(make_point(2, 7, 8, 9, R_MAX, R_MIN, R_MAX, 7, 8, 9, 1'b0));
        send_point(make_point(0, 3, 4, 65536, '0, '0, '0, -9, 2, 1, 1'b0));
        send_point(make_point(3, '0, '0, C_MIN, '0, '0, R_MIN, '0, '0, C_MAX, 1'b1));

        // widest differences and rotation extremes
        send_point(make_point(3, C_MAX, '0, 1, R_MAX, '0, '0, C_MIN, '0, '0, 1'b0));
        send_point(make_point(0, C_MIN, C_MIN, C_MAX, R_MIN, R_MIN, R_MIN,
                              C_MAX, C_MAX, C_MIN, 1'b0));
        send_point(make_point(1, C_MAX, C_MAX, C_MAX, R_MAX, R_MAX, R_MAX,
                              C_MIN, C_MIN, C_MIN, 1'b0));
        send_point(front_point(3, 1'b1));

        // tie goes to the lower pose
        send_point(front_point(2, 1'b0));
        send_point(front_point(1, 1'b0));
        send_point(front_point(2, 1'b0));
        send_point(front_point(1, 1'b1));

        // last point is counted before the vote
        send_point(front_point(0, 1'b0));
        send_point(front_point(3, 1'b0));
        send_point(front_point(3, 1'b1));

        // lone point behind the camera of pose 2
        send_point(make_point(2, '0, '0, 100, '0, '0, R_MAX, '0, '0, 200, 1'b1));
        drain();

        while (rand_points < 1800) begin
            len    = ($urandom_range(9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 40);
            fav    = $urandom_range(3);
            steady = (rand_points >= 700 && rand_points < 1100);
            for (int n = 0; n < len; n++) begin
                pose = $urandom_range(1) ? fav : POSE_W'($urandom_range(3));
                send_point(rand_point(pose, n == len - 1));
                rand_points++;
            end
            if ($urandom_range(19) == 0) drain();
        end
        steady = 1'b0;
        drain();

        if (board.fails == 0)
            $display("cheirality_pose_vote_unit test passed");
        else
            $display("cheirality_pose_vote_unit test failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/cpv_pkg.sv
sv/cpv_in_if.sv
sv/cpv_out_if.sv
sv/cpv_front.sv
sv/cpv_queue.sv
sv/cpv_back.sv
sv/cheirality_pose_vote_unit.sv
sv/cpv_checker.sv
dv/cheirality_pose_vote_unit_tb.sv
